// ----- sv/ghp_pkg.sv -----
// Package for the gzip header parser: phase codes, status and field-kind
// codes, the parser state and result structs, and the optional-field lookup.
// No dependencies.
package ghp_pkg;

  // Phase code width, and the code width fixed by the channel fields.
  localparam int unsigned PhaseW = 5;
  localparam int unsigned CodeW  = 3;

  // Parser phase codes.
  localparam logic [PhaseW-1:0] PH_MAGIC0  = 5'd0;
  localparam logic [PhaseW-1:0] PH_MAGIC1  = 5'd1;
  localparam logic [PhaseW-1:0] PH_METHOD  = 5'd2;
  localparam logic [PhaseW-1:0] PH_FLAGS   = 5'd3;
  localparam logic [PhaseW-1:0] PH_MTIME0  = 5'd4;
  localparam logic [PhaseW-1:0] PH_MTIME1  = 5'd5;
  localparam logic [PhaseW-1:0] PH_MTIME2  = 5'd6;
  localparam logic [PhaseW-1:0] PH_MTIME3  = 5'd7;
  localparam logic [PhaseW-1:0] PH_XFL     = 5'd8;
  localparam logic [PhaseW-1:0] PH_OS      = 5'd9;
  localparam logic [PhaseW-1:0] PH_XLEN0   = 5'd10;
  localparam logic [PhaseW-1:0] PH_XLEN1   = 5'd11;
  localparam logic [PhaseW-1:0] PH_XDATA   = 5'd12;
  localparam logic [PhaseW-1:0] PH_NAME    = 5'd13;
  localparam logic [PhaseW-1:0] PH_COMMENT = 5'd14;
  localparam logic [PhaseW-1:0] PH_HCRC0   = 5'd15;
  localparam logic [PhaseW-1:0] PH_HCRC1   = 5'd16;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 5'd17;

  // Status codes; the error codes double as the sticky error register.
  localparam logic [CodeW-1:0] ST_IN_HEADER   = 3'd0;
  localparam logic [CodeW-1:0] ST_HEADER_DONE = 3'd1;
  localparam logic [CodeW-1:0] ERR_NONE       = 3'd0;
  localparam logic [CodeW-1:0] ERR_MAGIC      = 3'd2;
  localparam logic [CodeW-1:0] ERR_METHOD     = 3'd3;
  localparam logic [CodeW-1:0] ERR_RESV       = 3'd4;
  localparam logic [CodeW-1:0] ERR_TRUNC      = 3'd5;

  // Field-kind codes.
  localparam logic [CodeW-1:0] KIND_NONE    = 3'd0;
  localparam logic [CodeW-1:0] KIND_EXTRA   = 3'd1;
  localparam logic [CodeW-1:0] KIND_NAME    = 3'd2;
  localparam logic [CodeW-1:0] KIND_COMMENT = 3'd3;
  localparam logic [CodeW-1:0] KIND_PAYLOAD = 3'd4;

  // Header constants.
  localparam logic [15:0] GzipMagic    = 16'h8B1F;
  localparam logic [7:0]  MethodDeflate = 8'd8;
  localparam logic [7:0]  FlgResvMask   = 8'hE0;

  // FLG bit positions.
  localparam int unsigned FlgHcrc    = 1;
  localparam int unsigned FlgExtra   = 2;
  localparam int unsigned FlgName    = 3;
  localparam int unsigned FlgComment = 4;

  // Optional-field slots, in stream order.
  localparam logic [1:0] SLOT_EXTRA   = 2'd0;
  localparam logic [1:0] SLOT_NAME    = 2'd1;
  localparam logic [1:0] SLOT_COMMENT = 2'd2;
  localparam logic [1:0] SLOT_HCRC    = 2'd3;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [15:0]       byte_count;
    logic [7:0]        flags;
    logic [31:0]       mtime;
    logic [7:0]        xfl;
    logic [7:0]        os;
    logic [15:0]       hcrc;
    logic [CodeW-1:0]  err;
  } ghp_state_t;

  // One result item.
  typedef struct packed {
    logic [CodeW-1:0] status;
    logic [CodeW-1:0] field_kind;
    logic [7:0]       data_out;
    logic [7:0]       header_flags;
    logic [31:0]      mod_time;
    logic [7:0]       extra_flags;
    logic [7:0]       os_code;
    logic [15:0]      header_crc;
  } ghp_result_t;

  // First enabled optional field at or after the given slot, else payload.
  function automatic logic [PhaseW-1:0] next_field(input logic [1:0] slot,
                                                   input logic [7:0] flags);
    logic [PhaseW-1:0] ph;
    ph = PH_PAYLOAD;
    if (slot <= SLOT_HCRC && flags[FlgHcrc])          ph = PH_HCRC0;
    if (slot <= SLOT_COMMENT && flags[FlgComment])    ph = PH_COMMENT;
    if (slot <= SLOT_NAME && flags[FlgName])          ph = PH_NAME;
    if (slot == SLOT_EXTRA && flags[FlgExtra])        ph = PH_XLEN0;
    return ph;
  endfunction

endpackage

// ----- sv/ghp_ifs.sv -----
// Valid/ready stream interfaces for the gzip header parser: the byte input
// channel and the result channel. No dependencies.
interface ghp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface ghp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  field_kind;
  logic [7:0]  data_out;
  logic [7:0]  header_flags;
  logic [31:0] mod_time;
  logic [7:0]  extra_flags;
  logic [7:0]  os_code;
  logic [15:0] header_crc;

  modport source (output valid, output status, output field_kind, output data_out,
                  output header_flags, output mod_time, output extra_flags,
                  output os_code, output header_crc, input ready);
  modport sink   (input valid, input status, input field_kind, input data_out,
                  input header_flags, input mod_time, input extra_flags,
                  input os_code, input header_crc, output ready);
endinterface

// ----- sv/ghp_step.sv -----
// Combinational per-byte step of the gzip header parser: next parser state
// and the result item for one input byte. Depends on ghp_pkg.
module ghp_step (
  input  ghp_pkg::ghp_state_t  state_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 stream_end_i,
  output ghp_pkg::ghp_state_t  state_o,
  output ghp_pkg::ghp_result_t result_o
);
  import ghp_pkg::*;

  ghp_state_t       nx;
  logic [CodeW-1:0] kind;
  logic [15:0]      xlen;
  logic [15:0]      xcnt;

  // Phase update for one byte while no error is pending.
  always_comb begin
    nx   = state_i;
    kind = KIND_NONE;
    xlen = {data_byte_i, state_i.byte_count[7:0]};
    xcnt = state_i.byte_count - 16'd1;
    if (state_i.err == ERR_NONE) begin
      case (state_i.phase)
        PH_MAGIC0: begin
          nx.byte_count = {8'd0, data_byte_i};
          nx.phase      = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if ({data_byte_i, state_i.byte_count[7:0]} != GzipMagic) nx.err = ERR_MAGIC;
          nx.byte_count = 16'd0;
          nx.phase      = PH_METHOD;
        end
        PH_METHOD: begin
          if (data_byte_i != MethodDeflate) nx.err = ERR_METHOD;
          nx.phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          nx.flags = data_byte_i;
          if ((data_byte_i & FlgResvMask) != 8'd0) nx.err = ERR_RESV;
          nx.phase = PH_MTIME0;
        end
        PH_MTIME0, PH_MTIME1, PH_MTIME2, PH_MTIME3: begin
          nx.mtime = {data_byte_i, state_i.mtime[31:8]};
          nx.phase = state_i.phase + PhaseW'(1);
        end
        PH_XFL: begin
          nx.xfl   = data_byte_i;
          nx.phase = PH_OS;
        end
        PH_OS: begin
          nx.os    = data_byte_i;
          nx.phase = next_field(SLOT_EXTRA, state_i.flags);
        end
        PH_XLEN0: begin
          nx.byte_count = {8'd0, data_byte_i};
          nx.phase      = PH_XLEN1;
        end
        PH_XLEN1: begin
          // A zero length skips the extra field at once.
          nx.byte_count = xlen;
          nx.phase      = (xlen == 16'd0) ? next_field(SLOT_NAME, state_i.flags) : PH_XDATA;
        end
        PH_XDATA: begin
          kind          = KIND_EXTRA;
          nx.byte_count = xcnt;
          if (xcnt == 16'd0) nx.phase = next_field(SLOT_NAME, state_i.flags);
        end
        PH_NAME: begin
          if (data_byte_i == 8'd0) nx.phase = next_field(SLOT_COMMENT, state_i.flags);
          else                     kind     = KIND_NAME;
        end
        PH_COMMENT: begin
          if (data_byte_i == 8'd0) nx.phase = next_field(SLOT_HCRC, state_i.flags);
          else                     kind     = KIND_COMMENT;
        end
        PH_HCRC0: begin
          nx.hcrc  = {data_byte_i, state_i.hcrc[15:8]};
          nx.phase = PH_HCRC1;
        end
        PH_HCRC1: begin
          nx.hcrc  = {data_byte_i, state_i.hcrc[15:8]};
          nx.phase = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          kind = KIND_PAYLOAD;
        end
        default: begin
          nx.phase = PH_PAYLOAD;
        end
      endcase
      // A field error on this byte wins over truncation on the same byte.
      if (nx.err == ERR_NONE && stream_end_i && nx.phase != PH_PAYLOAD) nx.err = ERR_TRUNC;
      if (nx.err != ERR_NONE) kind = KIND_NONE;
    end
  end

  // Result item built from the updated state.
  always_comb begin
    state_o = nx;
    if (nx.err != ERR_NONE) result_o.status = nx.err;
    else result_o.status = (nx.phase == PH_PAYLOAD) ? ST_HEADER_DONE : ST_IN_HEADER;
    result_o.field_kind   = kind;
    result_o.data_out     = (kind != KIND_NONE) ? data_byte_i : 8'd0;
    result_o.header_flags = nx.flags;
    result_o.mod_time     = nx.mtime;
    result_o.extra_flags  = nx.xfl;
    result_o.os_code      = nx.os;
    result_o.header_crc   = nx.hcrc;
  end

endmodule

// ----- sv/gzip_header_parser.sv -----
// Top level of the gzip header parser: parser state register, per-byte step
// and the result register on the output channel.
// Depends on ghp_pkg, ghp_ifs (ghp_in_if, ghp_out_if) and ghp_step.

// The parser takes one byte of a gzip member per input transaction and
// returns exactly one result transaction for it. Each byte is handled by the
// combinational step: the state register and the step logic update together,
// and the result lands in an output register, offered in the next cycle.
// A new byte is accepted every cycle while the output register is empty or
// being drained, so the sustained rate is one byte per cycle; a stalled
// output holds off the input only while its single result register is full.
// Errors (bad magic, bad method, reserved flags, truncation) are sticky until
// reset, and the stream-end marker does not restart the parser.
module gzip_header_parser (
  input  logic     clk_i,
  input  logic     rst_ni,
  ghp_in_if.sink   in_if,
  ghp_out_if.source out_if
);
  import ghp_pkg::*;

  ghp_state_t  state_q, state_d;
  ghp_result_t res_q, res_d;
  logic        out_valid_q;
  logic        in_fire;

  // Input is taken whenever the result register is free or being drained.
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  ghp_step u_step (
    .state_i      (state_q),
    .data_byte_i  (in_if.data_byte),
    .stream_end_i (in_if.stream_end),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  // Parser state, advanced on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= PH_MAGIC0;
      state_q.byte_count <= 16'd0;
      state_q.flags      <= 8'd0;
      state_q.mtime      <= 32'd0;
      state_q.xfl        <= 8'd0;
      state_q.os         <= 8'd0;
      state_q.hcrc       <= 16'd0;
      state_q.err        <= ERR_NONE;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted byte.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.status       = res_q.status;
  assign out_if.field_kind   = res_q.field_kind;
  assign out_if.data_out     = res_q.data_out;
  assign out_if.header_flags = res_q.header_flags;
  assign out_if.mod_time     = res_q.mod_time;
  assign out_if.extra_flags  = res_q.extra_flags;
  assign out_if.os_code      = res_q.os_code;
  assign out_if.header_crc   = res_q.header_crc;

  // Once an error is recorded it never changes.
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.err != ERR_NONE |=> state_q.err == $past(state_q.err))
    else $error("sticky error code changed");

  // A captured header CRC implies the FHCRC flag was set.
  a_hcrc_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hcrc != 16'd0 |-> state_q.flags[FlgHcrc])
    else $error("header CRC captured without FHCRC");

  // Classified bytes are only reported while no error is pending.
  a_kind_no_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.field_kind != KIND_NONE |->
      (res_q.status == ST_IN_HEADER || res_q.status == ST_HEADER_DONE))
    else $error("field byte reported with an error status");

  // A byte taken in the payload phase comes out as payload.
  a_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && state_q.phase == PH_PAYLOAD && state_q.err == ERR_NONE |=>
      out_valid_q && res_q.field_kind == KIND_PAYLOAD)
    else $error("payload byte not classified as payload");

endmodule

// ----- tb/sv/gzip_header_parser_tb.sv -----
// Self-checking testbench for gzip_header_parser: one randomized gzip header
// followed by payload bytes, with a per-byte predictor and a result checker.
// Depends on ghp_pkg, ghp_ifs (ghp_in_if, ghp_out_if) and gzip_header_parser.
module gzip_header_parser_tb;
  import ghp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClassicItems = 1650;
  localparam int unsigned HoldCycles   = 48;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned DrainLimit   = 2000;
  localparam int unsigned SettleCycles = 8;

  // Only one reset per run and sticky errors mean one header per run; the
  // seed picks which kind of header this run carries.
  typedef enum int {
    HDR_BAD_MAGIC,
    HDR_BAD_METHOD,
    HDR_RESV_FLAGS,
    HDR_TRUNCATED,
    HDR_CLEAN
  } hdr_case_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } gz_byte_t;

  // Header parse state as the predictor tracks it.
  typedef struct {
    logic [PhaseW-1:0] stage;
    logic [15:0]       count;
    logic [7:0]        flg;
    logic [31:0]       mtime;
    logic [7:0]        xfl;
    logic [7:0]        os;
    logic [15:0]       crc;
    logic [CodeW-1:0]  err;
  } parse_state_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  ghp_in_if  in_ch ();
  ghp_out_if out_ch ();

  gzip_header_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  gz_byte_t    pending_bytes[$];
  ghp_result_t expected_results[$];
  parse_state_t hdr = '{stage: PH_MAGIC0, count: '0, flg: '0, mtime: '0, xfl: '0,
                        os: '0, crc: '0, err: ERR_NONE};

  int unsigned n_total;
  int unsigned n_accepted = 0;
  int unsigned hold_at;
  int unsigned pause_at;
  int unsigned mode_base;
  int unsigned mismatches = 0;
  int unsigned n_checked = 0;
  int unsigned quiet_cycles = 0;

  logic [1:0]  idle_mode;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  // Idle behavior rotates every hundred transactions: none, sender idle,
  // receiver stalling, both.
  assign idle_mode     = 2'((n_accepted / 100 + mode_base) % 4);
  assign src_idle_pct  = (idle_mode == 2'd1) ? 66 : (idle_mode == 2'd3) ? 22 : 0;
  assign snk_stall_pct = (idle_mode == 2'd2) ? 66 : (idle_mode == 2'd3) ? 22 : 0;

  // First optional field enabled at or after the given slot, else payload.
  function automatic logic [PhaseW-1:0] field_from(input logic [1:0] slot,
                                                   input logic [7:0] flg);
    if (slot == SLOT_EXTRA && flg[FlgExtra]) return PH_XLEN0;
    if (slot <= SLOT_NAME && flg[FlgName]) return PH_NAME;
    if (slot <= SLOT_COMMENT && flg[FlgComment]) return PH_COMMENT;
    if (flg[FlgHcrc]) return PH_HCRC0;
    return PH_PAYLOAD;
  endfunction

  // Advances the header state by one byte and returns the result it causes.
  function automatic ghp_result_t parse_byte(input logic [7:0] b, input logic last);
    ghp_result_t r;
    logic [CodeW-1:0] kind;
    kind = KIND_NONE;
    if (hdr.err == ERR_NONE) begin
      case (hdr.stage)
        PH_MAGIC0: begin
          hdr.count = {8'h00, b};
          hdr.stage = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if ({b, hdr.count[7:0]} != GzipMagic) hdr.err = ERR_MAGIC;
          hdr.count = '0;
          hdr.stage = PH_METHOD;
        end
        PH_METHOD: begin
          if (b != MethodDeflate) hdr.err = ERR_METHOD;
          hdr.stage = PH_FLAGS;
        end
        PH_FLAGS: begin
          hdr.flg = b;
          if ((b & FlgResvMask) != 8'h00) hdr.err = ERR_RESV;
          hdr.stage = PH_MTIME0;
        end
        PH_MTIME0, PH_MTIME1, PH_MTIME2, PH_MTIME3: begin
          hdr.mtime = {b, hdr.mtime[31:8]};
          hdr.stage = hdr.stage + 1'b1;
        end
        PH_XFL: begin
          hdr.xfl   = b;
          hdr.stage = PH_OS;
        end
        PH_OS: begin
          hdr.os    = b;
          hdr.stage = field_from(SLOT_EXTRA, hdr.flg);
        end
        PH_XLEN0: begin
          hdr.count = {8'h00, b};
          hdr.stage = PH_XLEN1;
        end
        PH_XLEN1: begin
          hdr.count = {b, hdr.count[7:0]};
          hdr.stage = (hdr.count == 16'd0) ? field_from(SLOT_NAME, hdr.flg) : PH_XDATA;
        end
        PH_XDATA: begin
          kind      = KIND_EXTRA;
          hdr.count = hdr.count - 16'd1;
          if (hdr.count == 16'd0) hdr.stage = field_from(SLOT_NAME, hdr.flg);
        end
        PH_NAME: begin
          if (b == 8'h00) hdr.stage = field_from(SLOT_COMMENT, hdr.flg);
          else kind = KIND_NAME;
        end
        PH_COMMENT: begin
          if (b == 8'h00) hdr.stage = field_from(SLOT_HCRC, hdr.flg);
          else kind = KIND_COMMENT;
        end
        PH_HCRC0: begin
          hdr.crc   = {b, hdr.crc[15:8]};
          hdr.stage = PH_HCRC1;
        end
        PH_HCRC1: begin
          hdr.crc   = {b, hdr.crc[15:8]};
          hdr.stage = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          kind = KIND_PAYLOAD;
        end
        default: begin
          hdr.stage = PH_PAYLOAD;
        end
      endcase
      // Any error on this byte takes precedence over truncation.
      if (hdr.err == ERR_NONE && last && hdr.stage != PH_PAYLOAD) hdr.err = ERR_TRUNC;
      if (hdr.err != ERR_NONE) kind = KIND_NONE;
    end

    if (hdr.err != ERR_NONE) r.status = hdr.err;
    else r.status = (hdr.stage == PH_PAYLOAD) ? ST_HEADER_DONE : ST_IN_HEADER;
    r.field_kind   = kind;
    r.data_out     = (kind != KIND_NONE) ? b : 8'h00;
    r.header_flags = hdr.flg;
    r.mod_time     = hdr.mtime;
    r.extra_flags  = hdr.xfl;
    r.os_code      = hdr.os;
    r.header_crc   = hdr.crc;
    return r;
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last = 1'b0);
    gz_byte_t item;
    item.data = b;
    item.last = last;
    pending_bytes = {pending_bytes, item};
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
                 $time, n_checked, what, want, got);
      mismatches++;
    end
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Build the byte stream: a header shaped by the chosen case, then payload.
  initial begin
    hdr_case_e  hcase;
    int unsigned pick;
    int unsigned hdr_len;
    int unsigned mark_at;
    int unsigned n_payload;
    int unsigned field_len;
    logic [15:0] magic_word;
    logic [15:0] xlen;
    logic [7:0]  method;
    logic [7:0]  flg;
    logic [31:0] mtime;
    logic        mark_end;

    mode_base  = $urandom_range(0, 3);
    pick       = $urandom_range(0, 9);
    hcase      = (pick < 4) ? hdr_case_e'(pick) : HDR_CLEAN;

    // Magic: either one bit flipped or a random word that is not the magic.
    magic_word = GzipMagic;
    if (hcase == HDR_BAD_MAGIC) begin
      if ($urandom_range(0, 1) != 0) begin
        magic_word = GzipMagic ^ (16'h0001 << $urandom_range(0, 15));
      end else begin
        do magic_word = 16'($urandom); while (magic_word == GzipMagic);
      end
    end
    add_byte(magic_word[7:0]);
    add_byte(magic_word[15:8]);

    method = MethodDeflate;
    if (hcase == HDR_BAD_METHOD) method = MethodDeflate ^ (8'h01 << $urandom_range(0, 7));
    add_byte(method);

    // Each optional field is present three times in four.
    flg             = 8'h00;
    flg[0]          = 1'($urandom_range(0, 1));
    flg[FlgHcrc]    = ($urandom_range(0, 3) != 0);
    flg[FlgExtra]   = ($urandom_range(0, 3) != 0);
    flg[FlgName]    = ($urandom_range(0, 3) != 0);
    flg[FlgComment] = ($urandom_range(0, 3) != 0);
    if (hcase == HDR_RESV_FLAGS) flg[7:5] = 3'($urandom_range(1, 7));
    add_byte(flg);

    case ($urandom_range(0, 2))
      0:       mtime = 32'h0000_0000;
      1:       mtime = 32'hFFFF_FFFF;
      default: mtime = $urandom;
    endcase
    for (int i = 0; i < 4; i++) add_byte(mtime[8*i +: 8]);
    add_byte(8'($urandom));
    add_byte(8'($urandom));

    // Extra field: empty, one with a nonzero upper length byte, or short.
    if (flg[FlgExtra]) begin
      case ($urandom_range(0, 3))
        0:       xlen = 16'd0;
        1:       xlen = 16'd256;
        default: xlen = 16'($urandom_range(1, 24));
      endcase
      add_byte(xlen[7:0]);
      add_byte(xlen[15:8]);
      for (int i = 0; i < int'(xlen); i++) add_byte(8'($urandom));
    end
    if (flg[FlgName]) begin
      field_len = $urandom_range(0, 12);
      for (int i = 0; i < int'(field_len); i++) add_byte(8'($urandom_range(1, 255)));
      add_byte(8'h00);
    end
    if (flg[FlgComment]) begin
      field_len = $urandom_range(0, 12);
      for (int i = 0; i < int'(field_len); i++) add_byte(8'($urandom_range(1, 255)));
      add_byte(8'h00);
    end
    if (flg[FlgHcrc]) begin
      add_byte(8'($urandom));
      add_byte(8'($urandom));
    end
    hdr_len = pending_bytes.size();

    // Place the end-of-stream marker: on the faulty byte now and then, inside
    // the header for truncation, or now and then exactly on the last header byte.
    mark_end = 1'($urandom_range(0, 1));
    case (hcase)
      HDR_BAD_MAGIC:  mark_at = 1;
      HDR_BAD_METHOD: mark_at = 2;
      HDR_RESV_FLAGS: mark_at = 3;
      HDR_TRUNCATED: begin
        mark_at  = $urandom_range(0, hdr_len - 2);
        mark_end = 1'b1;
      end
      default:        mark_at = hdr_len - 1;
    endcase
    pending_bytes[mark_at].last = mark_end;

    // Payload fills the run up to the item count, with extreme byte values
    // favored and scattered stream ends.
    n_payload = ClassicItems - hdr_len;
    for (int i = 0; i < int'(n_payload); i++) begin
      case ($urandom_range(0, 7))
        0:       add_byte(8'h00, ($urandom_range(0, 15) == 0));
        1:       add_byte(8'hFF, ($urandom_range(0, 15) == 0));
        default: add_byte(8'($urandom), ($urandom_range(0, 15) == 0));
      endcase
    end

    n_total  = pending_bytes.size();
    hold_at  = n_total / 3;
    pause_at = (2 * n_total) / 3;
  end

  // Input driver: offers the next pending byte, holding it until taken.
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    gz_byte_t    item;
    int unsigned n_sent;
    bit          pausing;
    bit          pause_used;
    if (!rst_ni) begin
      in_ch.valid      <= 1'b0;
      in_ch.data_byte  <= 8'h00;
      in_ch.stream_end <= 1'b0;
      n_sent     = 0;
      pausing    = 1'b0;
      pause_used = 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (!pause_used && n_sent == pause_at) begin
        pausing    = 1'b1;
        pause_used = 1'b1;
      end
      // Resume only once nothing is in flight and every result has come.
      if (pausing && !in_ch.valid && !out_ch.valid && expected_results.size() == 0)
        pausing = 1'b0;
      if (!pausing && pending_bytes.size() != 0 &&
          $urandom_range(0, 99) >= src_idle_pct) begin
        item = pending_bytes.pop_front();
        n_sent++;
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= item.data;
        in_ch.stream_end <= item.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin : result_ready
    int unsigned hold_left;
    bit          hold_used;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_used = 1'b0;
    end else if (!hold_used && n_accepted >= hold_at) begin
      hold_used = 1'b1;
      hold_left = HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Monitor: checks each result transaction, then predicts for each byte taken.
  always @(posedge clk_i) begin : result_monitor
    ghp_result_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %0d arrived with none expected", $time, n_checked);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("field_kind", 32'(want.field_kind), 32'(out_ch.field_kind));
          check_field("data_out", 32'(want.data_out), 32'(out_ch.data_out));
          check_field("header_flags", 32'(want.header_flags), 32'(out_ch.header_flags));
          check_field("mod_time", want.mod_time, out_ch.mod_time);
          check_field("extra_flags", 32'(want.extra_flags), 32'(out_ch.extra_flags));
          check_field("os_code", 32'(want.os_code), 32'(out_ch.os_code));
          check_field("header_crc", 32'(want.header_crc), 32'(out_ch.header_crc));
        end
        n_checked++;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results = {expected_results,
                            parse_byte(in_ch.data_byte, in_ch.stream_end)};
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("gzip_header_parser_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset once, then wait for the stream to drain and report.
  initial begin
    int unsigned drain;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (n_accepted != n_total);
    drain = 0;
    while (expected_results.size() != 0 && drain < DrainLimit) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("gzip_header_parser_tb: clean");
    end else begin
      $display("gzip_header_parser_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ghp_pkg.sv
sv/ghp_ifs.sv
sv/ghp_step.sv
sv/gzip_header_parser.sv
tb/sv/gzip_header_parser_tb.sv
